// File: rtl/core/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Types and constants shared by the PCX run-length decoder modules.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

	localparam int SIDE_W   = 16;
	localparam int ROW_W    = 13;
	localparam int RUN_W    = 6;
	localparam int BYTE_W   = 8;
	localparam int RGB_W    = 24;
	localparam int POS_W    = 12;
	localparam int PAL_DEPTH = 256;

	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_PALETTE = 2'd1;
	localparam logic [1:0] CMD_START   = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LINE   = 2'd2;

	localparam logic [BYTE_W-1:0] RUN_MARK  = 8'hc0;
	localparam logic [BYTE_W-1:0] RUN_MASK  = 8'h3f;
	localparam logic [BYTE_W-1:0] ALPHA_ONE = 8'hff;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_CLOSE
	} state_t;

	// effective (clamped) geometry
	typedef struct packed {
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
		logic [SIDE_W-1:0] line;
	} geom_t;

endpackage

// File: rtl/core/pcxrle_ram.sv
// ----------------------------------------------------------------------------
// pcxrle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcxrle_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/pcxrle_ctrl.sv
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Decode sequencer: run header tracking, shared column counter that steps
// one decoded byte per cycle unless m_tready stalls, row close, output register.
// ----------------------------------------------------------------------------
module pcxrle_ctrl
	import pcxrle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  geom_t             geom,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [BYTE_W-1:0] coded_byte,
	output logic              pal_re,
	input  logic [RGB_W-1:0]  pal_rgb,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,  // color_index, red, green, blue, alpha, column, row
	output logic              m_tlast   // last_of_run
);

	state_t state_q, state_d;

	logic [SIDE_W-1:0] col_q;
	logic [ROW_W-1:0]  row_q;
	logic [RUN_W-1:0]  pend_q;
	logic              await_q;
	logic [RUN_W-1:0]  rem_q;
	logic [BYTE_W-1:0] val_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_index_q;
	logic [RGB_W-1:0]  out_rgb_q;
	logic [POS_W-1:0]  out_col_q;
	logic [POS_W-1:0]  out_row_q;
	logic              out_last_q;

	logic accept;
	logic active;
	logic is_header;
	logic take_run;
	logic step;
	logic emit;
	logic in_width;
	logic [SIDE_W-1:0] col_next;

	assign accept    = in_valid && in_ready;
	assign active    = {{(SIDE_W-ROW_W){1'b0}}, row_q} < geom.height;
	assign is_header = (coded_byte & RUN_MARK) == RUN_MARK;
	assign in_width  = col_q < geom.width;
	assign col_next  = col_q + SIDE_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take_run) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (rem_q == '0) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		take_run = accept && (cmd == CMD_DATA) && active && (await_q || !is_header);
		pal_re   = take_run;
		step     = (state_q == ST_RUN) && (rem_q != '0) &&
		           (!in_width || !out_valid_q || m_tready);
		emit     = step && in_width;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
			await_q <= 1'b0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (cmd)
					CMD_DATA: begin
						if (active) begin
							if (await_q) begin
								rem_q   <= pend_q;
								pend_q  <= '0;
								await_q <= 1'b0;
							end else if (is_header) begin
								pend_q  <= RUN_W'(coded_byte & RUN_MASK);
								await_q <= 1'b1;
							end else begin
								rem_q <= RUN_W'(1);
							end
						end
					end
					CMD_START: begin
						col_q   <= '0;
						row_q   <= '0;
						pend_q  <= '0;
						await_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (step) begin
				col_q <= col_next;
				rem_q <= rem_q - RUN_W'(1);
			end
			if (state_q == ST_CLOSE && col_q >= geom.line) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_run) begin
			val_q <= coded_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_index_q <= val_q;
			out_rgb_q   <= pal_rgb;
			out_col_q   <= col_q[POS_W-1:0];
			out_row_q   <= row_q[POS_W-1:0];
			out_last_q  <= (rem_q == RUN_W'(1)) || (col_next == geom.width);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_row_q, out_col_q, ALPHA_ONE,
	                   out_rgb_q[7:0], out_rgb_q[15:8], out_rgb_q[23:16], out_index_q};

endmodule

// File: rtl/core/pcxrle_decoder_top.sv
// ----------------------------------------------------------------------------
// pcx_rle_decoder_top
// Run-length decoder for 8-bit single-plane PCX pixel data with palette
// lookup.
// ----------------------------------------------------------------------------
// A literal data byte passes through accept, pixel, run end and row close,
// and a run adds its header and one pixel step per decoded byte, since the
// shared column counter advances one decoded byte per cycle and the palette
// is read once per run or literal from a registered-read RAM. Run headers,
// palette writes, start items and ignored bytes are taken while idle. Pixel
// emission, and the column counter within the width, waits on m_tready.
// Pixels come in order with tlast on the final pixel an input transfer yields.
module pcx_rle_decoder_top
	import pcxrle_pkg::*;
#(
	parameter int MAX_SIDE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // coded_byte, palette_slot, palette_color
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // color_index, red, green, blue, alpha, column, row
	output logic        m_tlast    // last_of_run
);

	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [14:0] line_q;
	geom_t       geom;

	logic              pal_we;
	logic              pal_re;
	logic [RGB_W-1:0]  pal_rgb;
	logic [BYTE_W-1:0] coded_byte;
	logic [BYTE_W-1:0] pal_slot;
	logic [RGB_W-1:0]  pal_color;

	assign coded_byte = s_tdata[7:0];
	assign pal_slot   = s_tdata[15:8];
	assign pal_color  = s_tdata[39:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1;
			height_q <= 13'd1;
			line_q   <= 15'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[12:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_LINE:   line_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		geom.width  = {3'b000, width_q} > SIDE_MAX ? SIDE_MAX : {3'b000, width_q};
		geom.height = {3'b000, height_q} > SIDE_MAX ? SIDE_MAX : {3'b000, height_q};
		geom.line   = (line_q == '0) ? SIDE_W'(1) : {1'b0, line_q};
	end

	assign pal_we = s_tvalid && s_tready && (s_tuser == CMD_PALETTE);

	pcxrle_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PAL_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(pal_slot),
		.wdata(pal_color),
		.re   (pal_re),
		.raddr(coded_byte),
		.rdata(pal_rgb)
	);

	pcxrle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (s_tuser),
		.coded_byte(coded_byte),
		.pal_re    (pal_re),
		.pal_rgb   (pal_rgb),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives palette loads, run-length coded pixel bytes and start items into the
// PCX decoder under several image geometries. Expected pixels are predicted
// from a local copy of palette, geometry and decode position, and every output
// transfer is checked against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
	import pcxrle_pkg::*;
();

	localparam int SIDE_LIMIT = 4096;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic        last;
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  alpha;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  idx;
	} pixel_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // coded_byte, palette_slot, palette_color
	logic [1:0]  s_tuser = '0;   // command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // color_index, red, green, blue, alpha, column, row
	logic        m_tlast;        // last_of_run

	// decoder state as predicted
	logic [23:0] palette_copy [PAL_DEPTH];
	logic [15:0] col_pos = '0;
	logic [12:0] row_pos = '0;
	logic [5:0]  run_len = '0;
	logic        run_armed = 1'b0;
	logic [12:0] geo_width = 13'd1;
	logic [12:0] geo_height = 13'd1;
	logic [14:0] geo_line = 15'd1;

	pixel_t pixels_due [$];
	int     mismatches = 0;
	int     items_used = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;

	pcx_rle_decoder_top #(.MAX_SIDE(SIDE_LIMIT)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic string describe(input pixel_t p);
		return $sformatf("index %02h rgb %02h%02h%02h alpha %02h col %0d row %0d last %0b",
			p.idx, p.red, p.green, p.blue, p.alpha, p.col, p.row, p.last);
	endfunction

	function automatic void note_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tlast, m_tdata};
			if (pixels_due.size() == 0) begin
				note_error($sformatf("unexpected pixel: %s", describe(got)));
			end else begin
				want = pixels_due.pop_front();
				if (got.idx !== want.idx || got.red !== want.red ||
						got.green !== want.green || got.blue !== want.blue ||
						got.alpha !== want.alpha || got.col !== want.col ||
						got.row !== want.row || got.last !== want.last)
					note_error($sformatf("pixel mismatch\n  expected %s\n  actual   %s",
						describe(want), describe(got)));
			end
		end
	end

	task automatic emit_pixels(input logic [7:0] value, input int count);
		int     width_eff;
		int     line_eff;
		int     i;
		pixel_t px;
		pixel_t run_px [$];
		width_eff = (geo_width > SIDE_LIMIT) ? SIDE_LIMIT : geo_width;
		line_eff = (geo_line == 0) ? 1 : geo_line;
		for (i = 0; i < count; i++) begin
			if (col_pos < width_eff) begin
				px.idx = value;
				px.red = palette_copy[value][23:16];
				px.green = palette_copy[value][15:8];
				px.blue = palette_copy[value][7:0];
				px.alpha = ALPHA_ONE;
				px.col = col_pos[11:0];
				px.row = row_pos[11:0];
				px.last = 1'b0;
				run_px.push_back(px);
			end
			col_pos = col_pos + 16'd1;
		end
		if (run_px.size() > 0)
			run_px[run_px.size() - 1].last = 1'b1;
		foreach (run_px[k])
			pixels_due.push_back(run_px[k]);
		if (col_pos >= line_eff) begin
			col_pos = '0;
			row_pos = row_pos + 13'd1;
		end
	endtask

	// returns 0 for items the decoder ignores
	task automatic decode_item(input logic [1:0] cmd, input logic [7:0] code,
			input logic [7:0] slot, input logic [23:0] color, output bit used);
		int height_eff;
		used = 1'b1;
		height_eff = (geo_height > SIDE_LIMIT) ? SIDE_LIMIT : geo_height;
		case (cmd)
			CMD_PALETTE: palette_copy[slot] = color;
			CMD_START: begin
				col_pos = '0;
				row_pos = '0;
				run_len = '0;
				run_armed = 1'b0;
			end
			CMD_DATA: begin
				if (row_pos >= height_eff) begin
					used = 1'b0;
				end else if (run_armed) begin
					run_armed = 1'b0;
					emit_pixels(code, run_len);
					run_len = '0;
				end else if ((code & RUN_MARK) == RUN_MARK) begin
					run_len = 6'(code & RUN_MASK);
					run_armed = 1'b1;
				end else begin
					emit_pixels(code, 1);
				end
			end
			default: used = 1'b0;
		endcase
	endtask

	task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
			input logic [7:0] slot, input logic [23:0] color);
		bit used;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {color, slot, code};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_item(cmd, code, slot, color, used);
		if (used)
			items_used++;
	endtask

	task automatic send_byte(input logic [7:0] code);
		send_item(CMD_DATA, code, 8'($urandom), 24'($urandom));
	endtask

	task automatic send_palette(input logic [7:0] slot, input logic [23:0] color);
		send_item(CMD_PALETTE, 8'($urandom), slot, color);
	endtask

	task automatic send_start();
		send_item(CMD_START, 8'($urandom), 8'($urandom), 24'($urandom));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [14:0] w_data, input logic [14:0] h_data,
			input logic [14:0] l_data);
		logic [1:0]  idx [3];
		logic [14:0] val [3];
		int          k;
		idx = '{REG_WIDTH, REG_HEIGHT, REG_LINE};
		val = '{w_data, h_data, l_data};
		for (k = 0; k < 3; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		geo_width = w_data[12:0];
		geo_height = h_data[12:0];
		geo_line = l_data;
	endtask

	task automatic test_palette_load();
		int s;
		for (s = 0; s < PAL_DEPTH; s++)
			send_palette(8'(s), 24'($urandom));
	endtask

	// geometry still at its reset values: one pixel per row, one row
	task automatic test_reset_geometry();
		send_byte(8'h00);
		send_byte(8'h3f);
		send_start();
		send_byte(8'hc3);
		send_byte(8'h80);
		send_start();
	endtask

	task automatic test_runs();
		wait_idle();
		set_geometry(15'd8, 15'd3, 15'd10);
		send_byte(8'h00);
		send_byte(8'hbf);
		send_byte(8'h7f);
		send_byte(8'hc5);
		send_item(CMD_UNUSED, 8'hff, 8'hff, 24'hffffff);
		send_palette(8'h55, 24'h00ff00);
		send_byte(8'h55);
		send_byte(8'hc0);
		send_byte(8'h12);
		// run past the width and the line end: nothing kept, row closes
		send_byte(8'hff);
		send_byte(8'hc3);
		send_byte(8'hff);
		send_byte(8'hc3);
		send_byte(8'hc7);
		send_start();
		send_byte(8'h01);
		send_byte(8'hc1);
		send_byte(8'hff);
	endtask

	task automatic test_extremes();
		wait_idle();
		set_geometry(15'd0, 15'd2, 15'd0);
		send_start();
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		wait_idle();
		set_geometry(15'h1fff, 15'd0, 15'd5);
		send_start();
		send_byte(8'h10);
		wait_idle();
		set_geometry(15'h1fff, 15'h1fff, 15'h7fff);
		send_start();
		send_byte(8'hff);
		send_byte(8'h42);
		send_byte(8'hff);
		send_byte(8'h43);
	endtask

	task automatic test_random(input int count, input int send_pct, input int recv_pct);
		int first;
		int next_cfg;
		int pick;
		int w;
		int h;
		int l;
		bit done;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		first = items_used;
		next_cfg = items_used;
		while (items_used - first < count) begin
			if (items_used >= next_cfg) begin
				wait_idle();
				case ($urandom_range(0, 9))
					0: w = 0;
					1: w = $urandom_range(4096, 8191);
					default: w = $urandom_range(1, 24);
				endcase
				case ($urandom_range(0, 9))
					0: h = $urandom_range(4096, 8191);
					default: h = $urandom_range(1, 10);
				endcase
				case ($urandom_range(0, 9))
					0: l = 0;
					1: l = 32767;
					2: l = $urandom_range(1, (w > 0) ? ((w > SIDE_LIMIT) ? SIDE_LIMIT : w) : 1);
					default: l = ((w > SIDE_LIMIT) ? SIDE_LIMIT : w) + $urandom_range(0, 12);
				endcase
				set_geometry(15'($urandom_range(0, 3) << 13) | 15'(w),
					15'($urandom_range(0, 3) << 13) | 15'(h), 15'(l));
				if ($urandom_range(0, 2) != 0)
					send_start();
				next_cfg = items_used + 50;
			end
			done = row_pos >= ((geo_height > SIDE_LIMIT) ? SIDE_LIMIT : geo_height);
			pick = $urandom_range(0, 99);
			if (done && pick < 50) begin
				send_start();
			end else if (pick < 45) begin
				send_byte(RUN_MARK | 8'($urandom_range(0, 63)));
				send_byte(8'($urandom));
			end else if (pick < 80) begin
				send_byte(8'($urandom_range(0, 191)));
			end else if (pick < 86) begin
				send_palette(8'($urandom), 24'($urandom));
			end else if (pick < 90) begin
				send_start();
			end else if (pick < 93) begin
				send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 24'($urandom));
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 30;
		recv_stall_pct = 80;
		test_palette_load();
		test_reset_geometry();
		test_runs();
		test_extremes();
		test_random(8, 30, 80);
		test_random(8, 80, 30);
		test_random(6, 0, 0);
		wait_idle();
		if (mismatches == 0 && pixels_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
